// File: rtl/tcg_pkg.sv
// Shared constants, codes and state types of the toroidal cell grid store.
`default_nettype none

package tcg_pkg;

  localparam int unsigned MAX_RADIUS_DEF = 31;
  localparam int unsigned RADIUS_W       = 5;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd31;
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned MAG_W          = COORD_W;
  localparam int unsigned STEP_BITS      = 2;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned COUNT_W        = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_COUNT = 2'd3
  } tcg_mode_e;

  typedef enum logic [1:0] {
    MOD_IDLE,
    MOD_RUN,
    MOD_FIX
  } tcg_mod_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP_X,
    ST_WRAP_Y,
    ST_READ,
    ST_USE,
    ST_DONE
  } tcg_state_e;

endpackage

`default_nettype wire

// File: rtl/tcg_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module tcg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/tcg_mod.sv
// Iterative true-modulo unit: wraps a signed coordinate plus radius by the grid side.
`default_nettype none

module tcg_mod import tcg_pkg::*; #(
  parameter int unsigned AW = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [COORD_W-1:0]  coord_i,
  input  logic [RADIUS_W-1:0]        radius_i,
  input  logic [AW-1:0]              side_i,
  output logic                       done_o,
  output logic [AW-1:0]              rem_o
);

  localparam int unsigned NSTEPS = MAG_W / STEP_BITS;
  localparam int unsigned CW     = $clog2(NSTEPS);

  tcg_mod_state_e   state_q, state_d;
  logic [MAG_W-1:0] shreg_q, shreg_d;
  logic [AW-1:0]    rem_q, rem_d;
  logic             neg_q, neg_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  logic [COORD_W:0] sum;
  logic [COORD_W:0] sum_abs;
  logic [AW-1:0]    step_rem;
  logic [AW:0]      ext;

  assign sum     = {coord_i[COORD_W-1], coord_i} + (COORD_W+1)'(radius_i);
  assign sum_abs = sum[COORD_W] ? (~sum + 1'b1) : sum;

  always_comb begin
    step_rem = rem_q;
    ext      = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      ext = {step_rem, shreg_q[MAG_W-1-i]};
      if (ext >= {1'b0, side_i}) begin
        ext = ext - {1'b0, side_i};
      end
      step_rem = ext[AW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    shreg_d = shreg_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    case (state_q)
      MOD_RUN: begin
        rem_d   = step_rem;
        shreg_d = shreg_q << STEP_BITS;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CW'(NSTEPS - 1)) begin
          state_d = MOD_FIX;
        end
      end
      MOD_FIX: begin
        state_d = MOD_IDLE;
      end
      default: begin
        state_d = MOD_IDLE;
      end
    endcase
    if (start_i) begin
      state_d = MOD_RUN;
      shreg_d = sum_abs[MAG_W-1:0];
      neg_d   = sum[COORD_W];
      rem_d   = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MOD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
    cnt_q   <= cnt_d;
  end

  assign done_o = (state_q == MOD_FIX);
  assign rem_o  = (neg_q && rem_q != '0) ? (side_i - rem_q) : rem_q;

endmodule

`default_nettype wire

// File: rtl/toroidal_cell_grid_store.sv
// Toroidal cell grid store: top level with sequencer, row store and result register.
// Each coordinate is wrapped by the shared remainder unit, two quotient bits a cycle,
// in eight steps and a sign fix-up. The single row-store port then takes a read step
// and a use step per row touched (one row, or three for a count), and a done step moves
// the result to the output register. The next input is taken once it has moved there.
// Input is stalled while an item is in work. A finished result waits in the output
// register, and while that register stays stalled the next item holds in its last step.
// Reset clears the grid at once through per-row valid flags, so no clearing pass is needed.
`default_nettype none

module toroidal_cell_grid_store import tcg_pkg::*; #(
  parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [RADIUS_W-1:0]       cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [MODE_W-1:0]         mode_i,
  input  logic signed [COORD_W-1:0] x_coord_i,
  input  logic signed [COORD_W-1:0] y_coord_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      is_alive_o,
  output logic [COUNT_W-1:0]        neighbour_count_o
);

  localparam int unsigned W  = 2 * MAX_RADIUS + 1;
  localparam int unsigned AW = $clog2(W);
  localparam logic [1:0] ROW_MID  = 2'd1;
  localparam logic [1:0] ROW_LAST = 2'd2;

  tcg_state_e                  state_q, state_d;
  logic [RADIUS_W-1:0]         radius_q;
  tcg_mode_e                   mode_q, mode_d;
  logic signed [COORD_W-1:0]   y_q, y_d;
  logic [AW-1:0]               xm_q, xm_d;
  logic [AW-1:0]               row_m_q, row_m_d;
  logic [1:0]                  dy_q, dy_d;
  logic                        alive_q, alive_d;
  logic [COUNT_W-1:0]          cnt_q, cnt_d;
  logic                        rd_vld_q, rd_vld_d;
  logic [W-1:0]                row_vld_q, row_vld_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_alive_q, out_alive_d;
  logic [COUNT_W-1:0]          out_cnt_q, out_cnt_d;

  logic [RADIUS_W-1:0]         eff_r;
  logic [AW-1:0]               side;
  logic [AW-1:0]               base;
  logic                        mod_start;
  logic signed [COORD_W-1:0]   mod_coord;
  logic                        mod_done;
  logic [AW-1:0]               mod_rem;
  logic                        ram_we;
  logic                        ram_re;
  logic [AW-1:0]               row_addr;
  logic [W-1:0]                ram_wdata;
  logic [W-1:0]                ram_rdata;
  logic [W-1:0]                row_data;
  logic [W-1:0]                cell_mask;
  logic [AW-1:0]               ix_l, ix_c, ix_r;
  logic                        out_xfer;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] m, input logic [AW-1:0] s);
    return (m == s - 1'b1) ? '0 : m + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] m, input logic [AW-1:0] s);
    return (m == '0) ? s - 1'b1 : m - 1'b1;
  endfunction

  assign eff_r = (radius_q > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_q;
  assign side  = AW'({eff_r, 1'b1});
  assign base  = AW'(MAX_RADIUS) - AW'(eff_r);

  assign ix_c     = xm_q + base;
  assign ix_l     = wrap_dec(xm_q, side) + base;
  assign ix_r     = wrap_inc(xm_q, side) + base;
  assign row_addr = row_m_q + base;
  assign row_data = rd_vld_q ? ram_rdata : '0;
  assign cell_mask = W'(1) << ix_c;

  assign out_xfer = out_valid_q && !out_stall_i;

  tcg_mod #(
    .AW (AW)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mod_start),
    .coord_i  (mod_coord),
    .radius_i (eff_r),
    .side_i   (side),
    .done_o   (mod_done),
    .rem_o    (mod_rem)
  );

  tcg_ram #(
    .WIDTH (W),
    .DEPTH (W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (row_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    y_d         = y_q;
    xm_d        = xm_q;
    row_m_d     = row_m_q;
    dy_d        = dy_q;
    alive_d     = alive_q;
    cnt_d       = cnt_q;
    rd_vld_d    = rd_vld_q;
    row_vld_d   = row_vld_q;
    out_alive_d = out_alive_q;
    out_cnt_d   = out_cnt_q;
    out_valid_d = out_valid_q && !out_xfer;
    mod_start   = 1'b0;
    mod_coord   = x_coord_i;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          mode_d    = tcg_mode_e'(mode_i);
          y_d       = y_coord_i;
          alive_d   = 1'b0;
          cnt_d     = '0;
          mod_start = 1'b1;
          state_d   = ST_WRAP_X;
        end
      end
      ST_WRAP_X: begin
        mod_coord = y_q;
        if (mod_done) begin
          xm_d      = mod_rem;
          mod_start = 1'b1;
          state_d   = ST_WRAP_Y;
        end
      end
      ST_WRAP_Y: begin
        if (mod_done) begin
          row_m_d = (mode_q == MODE_COUNT) ? wrap_dec(mod_rem, side) : mod_rem;
          dy_d    = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_re   = 1'b1;
        rd_vld_d = row_vld_q[row_addr];
        state_d  = ST_USE;
      end
      ST_USE: begin
        if (mode_q inside {MODE_SET, MODE_CLEAR}) begin
          ram_we              = 1'b1;
          ram_wdata           = (mode_q == MODE_SET) ? (row_data | cell_mask)
                                                     : (row_data & ~cell_mask);
          row_vld_d[row_addr] = 1'b1;
          state_d             = ST_DONE;
        end else if (mode_q == MODE_QUERY) begin
          alive_d = row_data[ix_c];
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + COUNT_W'(row_data[ix_l]) + COUNT_W'(row_data[ix_r])
                + COUNT_W'(row_data[ix_c] && dy_q != ROW_MID);
          if (dy_q == ROW_LAST) begin
            state_d = ST_DONE;
          end else begin
            dy_d    = dy_q + 1'b1;
            row_m_d = wrap_inc(row_m_q, side);
            state_d = ST_READ;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_alive_d = alive_q;
          out_cnt_d   = cnt_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= RADIUS_RESET;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_vld_q   <= row_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    y_q         <= y_d;
    xm_q        <= xm_d;
    row_m_q     <= row_m_d;
    dy_q        <= dy_d;
    alive_q     <= alive_d;
    cnt_q       <= cnt_d;
    rd_vld_q    <= rd_vld_d;
    out_alive_q <= out_alive_d;
    out_cnt_q   <= out_cnt_d;
  end

  assign out_valid_o       = out_valid_q;
  assign is_alive_o        = out_alive_q;
  assign neighbour_count_o = out_cnt_q;

endmodule

`default_nettype wire

// File: rtl/tcg_checker.sv
// Port-level checker for the toroidal cell grid store, bound to the top level.
`default_nettype none

module tcg_checker import tcg_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_o,
  input  logic [MODE_W-1:0]         mode_i,
  input  logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  logic                      is_alive_o,
  input  logic [COUNT_W-1:0]        neighbour_count_o
);

  logic [MODE_W-1:0] fifo0_q, fifo1_q;
  logic [1:0]        cnt_q;
  logic              push, pop;
  logic              wr_idx;

  assign push       = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;
  assign wr_idx     = cnt_q[0] ^ pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      fifo0_q <= '0;
      fifo1_q <= '0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
      if (push && !wr_idx) begin
        fifo0_q <= mode_i;
      end else if (pop) begin
        fifo0_q <= fifo1_q;
      end
      if (push && wr_idx) begin
        fifo1_q <= mode_i;
      end
    end
  end

  a_stall_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> in_stall_o)
    else $error("input taken while previous item still in work");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != 2'd0) && (neighbour_count_o <= COUNT_W'(8)))
    else $error("result without pending item or count out of range");

  a_alive_only_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fifo0_q != MODE_QUERY) |-> !is_alive_o)
    else $error("live flag set outside query");

  a_count_only_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fifo0_q != MODE_COUNT) |-> (neighbour_count_o == '0))
    else $error("neighbour count set outside count");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("more items in flight than the block can hold");

endmodule

bind toroidal_cell_grid_store tcg_checker u_tcg_checker (.*);

`default_nettype wire
